>>> hw/rtl/iur_pkg.sv
// Shared types, event codes, handshake pattern and CRC helper for the image upload receiver.
package iur_pkg;

    localparam int LenW   = 21;
    localparam int OffW   = 20;
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    localparam logic [LenW-1:0] LIMIT_CAP  = 21'h100000;
    localparam logic [31:0]     CRC_POLY   = 32'hEDB88320;
    localparam logic [20:0]     MAX_LEN_RST = 21'h010000;

    typedef enum logic [2:0] {
        EV_READY    = 3'd0,
        EV_HS_RETRY = 3'd1,
        EV_LEN_REJ  = 3'd2,
        EV_LEN_ACK  = 3'd3,
        EV_DATA     = 3'd4,
        EV_CRC_OK   = 3'd5,
        EV_CRC_FAIL = 3'd6
    } t_ev_kind;

    typedef struct packed {
        logic [2:0]      kind;
        logic [7:0]      data;
        logic [OffW-1:0] offset;
    } t_event;

    // Handshake pattern "RECV?\n"
    function automatic logic [7:0] hs_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0: r = 8'h52;
            3'd1: r = 8'h45;
            3'd2: r = 8'h43;
            3'd3: r = 8'h56;
            3'd4: r = 8'h3F;
            3'd5: r = 8'h0A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/iur_front.sv
// Protocol front end: tracks the upload phase and turns bytes into events.
module iur_front import iur_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_cfg_we,
    input  logic [LenW-1:0] i_cfg_data,
    output logic            o_push,
    output t_event          o_event
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_CRC  = 4'b1000
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [LenW-1:0] r_cnt, n_cnt;
    logic            r_match, n_match;
    logic [31:0]     r_acc, n_acc;
    logic [LenW-1:0] r_img_len, n_img_len;
    logic [31:0]     r_crc, n_crc;
    logic [LenW-1:0] r_max_len;

    logic [31:0]     acc_full;
    logic [LenW-1:0] limit;
    logic [LenW-1:0] cnt_inc;
    logic            hs_ok;

    assign limit    = (r_max_len < LIMIT_CAP) ? r_max_len : LIMIT_CAP;
    assign acc_full = r_acc | ({24'b0, i_rx_byte} << {r_cnt[1:0], 3'b000});
    assign cnt_inc  = r_cnt + LenW'(1);
    assign hs_ok    = r_match && (i_rx_byte == hs_byte(r_cnt[2:0]));

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_match   = r_match;
        n_acc     = r_acc;
        n_img_len = r_img_len;
        n_crc     = r_crc;
        o_push    = 1'b0;
        o_event   = '0;
        if (i_accept) begin
            case (r_phase)
                PH_LEN, PH_CRC: begin
                    n_acc = acc_full;
                    n_cnt = cnt_inc;
                    if (r_cnt[1:0] == 2'd3) begin
                        o_push  = 1'b1;
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                        n_match = 1'b1;
                        n_acc   = '0;
                        if (r_phase == PH_LEN) begin
                            if (acc_full == 32'd0 || acc_full > {11'b0, limit}) begin
                                o_event.kind = EV_LEN_REJ;
                            end else begin
                                o_event.kind = EV_LEN_ACK;
                                n_img_len    = acc_full[LenW-1:0];
                                n_crc        = '1;
                                n_phase      = PH_DATA;
                            end
                        end else begin
                            o_event.kind = (acc_full == ~r_crc) ? EV_CRC_OK : EV_CRC_FAIL;
                        end
                    end
                end
                PH_DATA: begin
                    o_push         = 1'b1;
                    o_event.kind   = EV_DATA;
                    o_event.data   = i_rx_byte;
                    o_event.offset = r_cnt[OffW-1:0];
                    n_crc          = crc_byte(r_crc, i_rx_byte);
                    n_cnt          = cnt_inc;
                    if (cnt_inc >= r_img_len) begin
                        n_phase = PH_CRC;
                        n_cnt   = '0;
                        n_acc   = '0;
                    end
                end
                default: begin
                    // idle: six-byte handshake window, verdict only at the end
                    n_phase = PH_IDLE;
                    n_match = hs_ok;
                    n_cnt   = cnt_inc;
                    if (r_cnt[2:0] == 3'd5) begin
                        o_push       = 1'b1;
                        o_event.kind = hs_ok ? EV_READY : EV_HS_RETRY;
                        n_cnt        = '0;
                        n_match      = 1'b1;
                        n_acc        = '0;
                        if (hs_ok) begin
                            n_phase = PH_LEN;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_match   <= 1'b1;
            r_acc     <= '0;
            r_img_len <= '0;
            r_crc     <= '1;
            r_max_len <= MAX_LEN_RST;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_match   <= n_match;
            r_acc     <= n_acc;
            r_img_len <= n_img_len;
            r_crc     <= n_crc;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

endmodule

>>> hw/rtl/iur_queue.sv
// Small event queue between the protocol front end and the output stage.
module iur_queue import iur_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    input  logic   i_pop,
    output logic   o_not_empty,
    output logic   o_full,
    output t_event o_head
);

    t_event            r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QPtrW:0]    r_count, n_count;

    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == (QPtrW+1)'(QDepth));
    assign o_head      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPtrW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPtrW'(1) : r_rd_ptr;
        n_count  = r_count + (QPtrW+1)'(i_push) - (QPtrW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> hw/rtl/iur_back.sv
// Output stage: drains the event queue into the result channel register.
module iur_back import iur_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_event i_q_head,
    output logic   o_pop,
    input  logic   i_stall,
    output logic   o_valid,
    output t_event o_event
);

    logic   r_valid, n_valid;
    t_event r_event;

    // refill when empty or when the current transfer completes
    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

>>> hw/rtl/image_upload_receiver_core.sv
// Image upload receiver: handshake, length, data stream and CRC check over a byte link.
//
// Input channel: one received byte per transfer (i_in_valid / o_in_stall).
// Output channel: one event per result (o_out_valid / i_out_stall) with kind, data byte
// and offset; data events carry the image byte and its offset. Configuration: i_cfg_we
// writes the length limit (i_cfg_data); the user must do so only while idle; not enforced.
// Throughput: one byte per cycle while o_in_stall is low; the protocol state,
// byte-wide CRC update and length compare all complete in the cycle the byte is taken.
// An event is written into the queue and then moved into the output register, where it is valid.
// A four-entry event queue sits between the protocol logic and the output
// register; o_in_stall rises only when that queue is full, which happens only
// while the receiver holds i_out_stall high. A stalled event stays unchanged.
// Reset (synchronous, active low) returns to the handshake phase, empties the
// queue, clears the output valid and sets the length limit to 65536.
module image_upload_receiver_core import iur_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_cfg_we,
    input  logic [LenW-1:0] i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_event_kind,
    output logic [7:0]      o_payload_byte,
    output logic [OffW-1:0] o_payload_offset
);

    logic   accept;
    logic   push;
    t_event fe_event;
    logic   q_not_empty;
    logic   q_full;
    t_event q_head;
    logic   pop;
    t_event out_event;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    iur_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_event    (fe_event)
    );

    iur_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_event     (fe_event),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_full      (q_full),
        .o_head      (q_head)
    );

    iur_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_not_empty),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_event   (out_event)
    );

    assign o_event_kind     = out_event.kind;
    assign o_payload_byte   = out_event.data;
    assign o_payload_offset = out_event.offset;

endmodule
